FILE: hdl/klex_pkg.sv
package klex_pkg;

	typedef enum logic [4:0] {
		KIND_SEMI   = 5'd0,
		KIND_PLUS   = 5'd1,
		KIND_MINUS  = 5'd2,
		KIND_TIMES  = 5'd3,
		KIND_DIV    = 5'd4,
		KIND_LP     = 5'd5,
		KIND_RP     = 5'd6,
		KIND_LT     = 5'd7,
		KIND_GT     = 5'd8,
		KIND_ASSIGN = 5'd9,
		KIND_COMP   = 5'd10,
		KIND_NUM    = 5'd11,
		KIND_ID     = 5'd12,
		KIND_IF     = 5'd13,
		KIND_DO     = 5'd14,
		KIND_END    = 5'd15,
		KIND_THEN   = 5'd16,
		KIND_WHILE  = 5'd17,
		KIND_BEGIN  = 5'd18,
		KIND_EOI    = 5'd19,
		KIND_ERROR  = 5'd20
	} tok_kind_t;

	// first five characters of a word, first character in the low byte
	localparam int PREFIX_CHARS = 5;
	localparam logic [39:0] KW_IF    = 40'h00_0000_6669;
	localparam logic [39:0] KW_DO    = 40'h00_0000_6F64;
	localparam logic [39:0] KW_END   = 40'h00_0064_6E65;
	localparam logic [39:0] KW_THEN  = 40'h00_6E65_6874;
	localparam logic [39:0] KW_WHILE = 40'h65_6C69_6877;
	localparam logic [39:0] KW_BEGIN = 40'h6E_6967_6562;

	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		tok_kind_t   kind;
		logic [10:0] len;
		logic [15:0] line;
		logic [9:0]  col;
		logic [7:0]  bad;
	} token_t;

	// everything one character produces: one or two tokens
	typedef struct packed {
		token_t t0;
		token_t t1;
		logic   two;
	} tok_pair_t;

endpackage

FILE: hdl/keyword_lexer.sv
// channel | dir | handshake             | beat payload
// input   | in  | in_valid / in_ready   | char_code, end_of_input
// output  | out | out_valid / out_ready | token_kind, lexeme_length, line_number,
//         |     |                       | start_column, bad_char, last
//
// Front end takes one character beat per cycle; in_ready only drops when
// the four-entry queue of token pairs is full.
// A character yields zero, one or two tokens; the back end sends one token
// beat per cycle while out_ready is high, so an item with two tokens holds
// the back end until both beats are taken. Tokens pass the queue, then the output reg.
// Reset (arst_n low) sets line 1, column 0, clears pending word and queue.
// Output stalls back up through the queue to in_ready, never losing a token.
module keyword_lexer #(
	parameter int MAX_LINE  = 1024,
	parameter int LINE_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_code,
	input  logic        end_of_input,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [4:0]  token_kind,
	output logic [10:0] lexeme_length,
	output logic [15:0] line_number,
	output logic [9:0]  start_column,
	output logic [7:0]  bad_char,
	output logic        last
);
	import klex_pkg::*;

	logic      take;
	logic      push;
	tok_pair_t pair;
	logic      q_valid;
	logic      q_pop;
	tok_pair_t q_data;
	token_t    tok;

	assign take = in_valid && in_ready;

	// front: word assembly, keyword match, line/column tracking
	klex_front #(
		.MAX_LINE (MAX_LINE),
		.LINE_BITS(LINE_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.char_code   (char_code),
		.end_of_input(end_of_input),
		.push        (push),
		.pair        (pair)
	);

	// decoupling queue of token pairs
	klex_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(pair),
		.not_full (in_ready),
		.pop      (q_pop),
		.not_empty(q_valid),
		.pop_data (q_data)
	);

	// back: serializes pairs into single-token beats
	klex_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (q_valid),
		.q_data   (q_data),
		.q_pop    (q_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.tok      (tok),
		.tok_last (last)
	);

	assign token_kind    = tok.kind;
	assign lexeme_length = tok.len;
	assign line_number   = tok.line;
	assign start_column  = tok.col;
	assign bad_char      = tok.bad;

	// EOI always closes its beat group
	a_eoi_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind == KIND_EOI |-> last)
		else $error("EOI token not marked last");

	// ERROR always closes its beat group
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind == KIND_ERROR |-> last)
		else $error("ERROR token not marked last");

	// only ERROR carries a bad character
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && token_kind != KIND_ERROR |-> bad_char == 8'h00)
		else $error("bad_char set on non-error token");

	// lines count from one
	a_line_nz: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> line_number != 16'h0000)
		else $error("line number zero");

endmodule

FILE: hdl/klex_front.sv
module klex_front #(
	parameter int MAX_LINE  = 1024,
	parameter int LINE_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                take,
	input  logic [7:0]          char_code,
	input  logic                end_of_input,
	output logic                push,
	output klex_pkg::tok_pair_t pair
);
	import klex_pkg::*;

	localparam int COL_W = $clog2(MAX_LINE);
	localparam int LEN_W = $clog2(MAX_LINE + 1);
	localparam int LN_W  = (LINE_BITS < 16) ? LINE_BITS : 16;

	logic              active_q;
	logic [39:0]       prefix_q;
	logic [LEN_W-1:0]  len_q;
	logic              digits_q;
	logic [COL_W-1:0]  wcol_q;
	logic [LN_W-1:0]   wline_q;
	logic [LN_W-1:0]   line_q;
	logic [COL_W-1:0]  col_q;
	logic              halted_q;

	logic is_digit, is_alnum, is_blank, is_nl, is_op;
	tok_kind_t op_kind, word_kind;
	token_t word_tok, char_tok;
	logic [COL_W-1:0] col_next;
	logic [39:0] prefix_next;

	assign is_digit = (char_code >= 8'h30) && (char_code <= 8'h39);
	assign is_alnum = is_digit
		|| ((char_code >= 8'h61) && (char_code <= 8'h7A))
		|| ((char_code >= 8'h41) && (char_code <= 8'h5A));
	assign is_blank = (char_code == 8'h20) || (char_code == 8'h09) || (char_code == 8'h0D);
	assign is_nl    = (char_code == 8'h0A);

	always_comb begin
		is_op   = 1'b1;
		op_kind = KIND_ERROR;
		unique case (char_code)
			8'h3B: op_kind = KIND_SEMI;
			8'h2B: op_kind = KIND_PLUS;
			8'h2D: op_kind = KIND_MINUS;
			8'h2A: op_kind = KIND_TIMES;
			8'h2F: op_kind = KIND_DIV;
			8'h28: op_kind = KIND_LP;
			8'h29: op_kind = KIND_RP;
			8'h3C: op_kind = KIND_LT;
			8'h3E: op_kind = KIND_GT;
			8'h3A: op_kind = KIND_ASSIGN;
			8'h3D: op_kind = KIND_COMP;
			default: is_op = 1'b0;
		endcase
	end

	always_comb begin
		word_kind = KIND_ID;
		if (digits_q) word_kind = KIND_NUM;
		else if (len_q == LEN_W'(2) && prefix_q == KW_IF) word_kind = KIND_IF;
		else if (len_q == LEN_W'(2) && prefix_q == KW_DO) word_kind = KIND_DO;
		else if (len_q == LEN_W'(3) && prefix_q == KW_END) word_kind = KIND_END;
		else if (len_q == LEN_W'(4) && prefix_q == KW_THEN) word_kind = KIND_THEN;
		else if (len_q == LEN_W'(5) && prefix_q == KW_WHILE) word_kind = KIND_WHILE;
		else if (len_q == LEN_W'(5) && prefix_q == KW_BEGIN) word_kind = KIND_BEGIN;
	end

	assign word_tok = '{kind: word_kind, len: 11'(len_q), line: 16'(wline_q),
		col: 10'(wcol_q), bad: 8'h00};

	always_comb begin
		char_tok = '{kind: KIND_EOI, len: 11'd0, line: 16'(line_q),
			col: 10'(col_q), bad: 8'h00};
		if (!end_of_input) begin
			char_tok.kind = is_op ? op_kind : KIND_ERROR;
			char_tok.len  = 11'd1;
			char_tok.bad  = is_op ? 8'h00 : char_code;
		end
	end

	assign col_next = (col_q < COL_W'(MAX_LINE - 1)) ? col_q + COL_W'(1) : col_q;

	always_comb begin
		prefix_next = prefix_q;
		for (int i = 0; i < PREFIX_CHARS; i++) begin
			if (len_q == LEN_W'(i)) prefix_next[8*i +: 8] = char_code;
		end
	end

	// token pair: pending word goes first when there is one
	always_comb begin
		push     = 1'b0;
		pair.two = 1'b0;
		pair.t0  = char_tok;
		pair.t1  = char_tok;
		if (take) begin
			if (end_of_input) begin
				push = 1'b1;
				if (active_q && !halted_q) begin
					pair.t0  = word_tok;
					pair.two = 1'b1;
				end
			end else if (!halted_q && !is_alnum) begin
				if (active_q) begin
					pair.t0 = word_tok;
					push    = 1'b1;
					pair.two = !(is_blank || is_nl);
				end else begin
					push = !(is_blank || is_nl);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			prefix_q <= '0;
			len_q    <= '0;
			digits_q <= 1'b1;
			wcol_q   <= '0;
			wline_q  <= LN_W'(1);
			line_q   <= LN_W'(1);
			col_q    <= '0;
			halted_q <= 1'b0;
		end else if (take) begin
			if (end_of_input) begin
				active_q <= 1'b0;
				prefix_q <= '0;
				len_q    <= '0;
				digits_q <= 1'b1;
				wcol_q   <= '0;
				wline_q  <= LN_W'(1);
				line_q   <= LN_W'(1);
				col_q    <= '0;
				halted_q <= 1'b0;
			end else if (!halted_q) begin
				if (is_alnum) begin
					if (!active_q) begin
						wcol_q  <= col_q;
						wline_q <= line_q;
					end
					active_q <= 1'b1;
					prefix_q <= prefix_next;
					if (len_q < LEN_W'(MAX_LINE)) len_q <= len_q + LEN_W'(1);
					if (!is_digit) digits_q <= 1'b0;
					col_q <= col_next;
				end else begin
					active_q <= 1'b0;
					prefix_q <= '0;
					len_q    <= '0;
					digits_q <= 1'b1;
					if (is_nl) begin
						if (line_q != '1) line_q <= line_q + LN_W'(1);
						col_q <= '0;
					end else begin
						col_q <= col_next;
						if (!is_blank && !is_op) halted_q <= 1'b1;
					end
				end
			end
		end
	end

endmodule

FILE: hdl/klex_queue.sv
module klex_queue (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  klex_pkg::tok_pair_t push_data,
	output logic                not_full,
	input  logic                pop,
	output logic                not_empty,
	output klex_pkg::tok_pair_t pop_data
);
	import klex_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	tok_pair_t        mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [PTR_W:0]   cnt_q;

	assign not_full  = (cnt_q != (PTR_W+1)'(QUEUE_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign pop_data  = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + PTR_W'(1);
			if (pop) rd_q <= rd_q + PTR_W'(1);
			cnt_q <= cnt_q + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
		end
	end

endmodule

FILE: hdl/klex_back.sv
module klex_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  klex_pkg::tok_pair_t q_data,
	output logic                q_pop,
	output logic                out_valid,
	input  logic                out_ready,
	output klex_pkg::token_t    tok,
	output logic                tok_last
);
	import klex_pkg::*;

	tok_pair_t cur_q;
	logic      vld_q;
	logic      sec_q;
	logic      load;

	assign tok_last  = !cur_q.two || sec_q;
	assign tok       = sec_q ? cur_q.t1 : cur_q.t0;
	assign out_valid = vld_q;
	assign load      = !vld_q || (out_ready && tok_last);
	assign q_pop     = load && q_valid;

	always_ff @(posedge clk) begin
		if (q_pop) cur_q <= q_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			sec_q <= 1'b0;
		end else if (load) begin
			vld_q <= q_valid;
			sec_q <= 1'b0;
		end else if (out_ready) begin
			sec_q <= 1'b1;
		end
	end

endmodule
